FILE: hdl/smtp_ds_pkg.sv
// Shared types and character constants for the SMTP dot-stuffing encoder.
`default_nettype none

package smtp_ds_pkg;

    // Request kinds on the input channel.
    localparam logic REQ_BODY = 1'b0;
    localparam logic REQ_EOB  = 1'b1;

    // Characters that steer the encoding.
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;

    // Most bytes a single request can produce (empty body at end of body).
    localparam int unsigned MAX_BYTES = 5;
    localparam int unsigned CNT_W     = $clog2(MAX_BYTES + 1);
    localparam int unsigned IDX_W     = $clog2(MAX_BYTES);

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
    } t_req;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_rsp;

    // Burst of output bytes produced by one request.
    typedef struct packed {
        logic [CNT_W-1:0]           cnt;
        logic [MAX_BYTES-1:0][7:0]  bytes;
    } t_burst;

endpackage

`default_nettype wire

FILE: hdl/smtp_dot_stuff_crlf_encoder_core.sv
// Top level of the SMTP DATA encoder: dot stuffing and CR LF line-end repair.
//
// Input channel (i_valid, o_stall, i_req): one request per body byte, or an
// end-of-body request that closes the message and sends the terminator.
// Output channel (o_valid, i_stall, o_rsp): the encoded byte stream, one
// byte per transfer; o_rsp.last marks the final byte caused by a request.
//
// The first byte of a request is shown in the cycle after it is accepted.
// While the receiver does not stall, one output byte leaves per cycle. A
// request that makes N bytes (up to five) holds the input until its last
// byte leaves the single output byte lane. The next request is taken in
// the cycle the last byte of the current burst leaves, so there are no
// bubbles.
//
// Reset clears the line state to the start of a message and drops any
// pending burst. While the receiver stalls, the current byte holds and
// new requests are stalled once a burst is waiting.
`default_nettype none

module smtp_dot_stuff_crlf_encoder_core (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  smtp_ds_pkg::t_req   i_req,
    output logic                o_valid,
    input  wire                 i_stall,
    output smtp_ds_pkg::t_rsp   o_rsp
);
    import smtp_ds_pkg::*;

    t_burst burst;
    logic   busy;
    logic   accept;

    assign o_stall = busy;
    assign accept  = i_valid && !busy;

    smtp_ds_expand u_expand (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (i_req),
        .o_burst  (burst)
    );

    smtp_ds_burst u_burst (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_burst  (burst),
        .o_busy   (busy),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_rsp    (o_rsp)
    );

endmodule

`default_nettype wire

FILE: hdl/smtp_ds_expand.sv
// Line state and expansion of one request into its burst of output bytes.
`default_nettype none

module smtp_ds_expand (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_accept,
    input  smtp_ds_pkg::t_req    i_req,
    output smtp_ds_pkg::t_burst  o_burst
);
    import smtp_ds_pkg::*;

    logic r_at_line_start;
    logic r_prev_was_cr;
    logic r_body_nonempty;

    logic n_at_line_start;
    logic n_prev_was_cr;
    logic n_body_nonempty;

    t_burst           burst;
    logic [CNT_W-1:0] k;

    // Build the byte burst and the next line state for the current request.
    always_comb begin
        burst           = '0;
        k               = '0;
        n_at_line_start = r_at_line_start;
        n_prev_was_cr   = r_prev_was_cr;
        n_body_nonempty = r_body_nonempty;
        if (i_req.req_type == REQ_BODY) begin
            if (i_req.data_byte == CH_LF) begin
                // A bare LF is repaired to CR LF.
                if (!r_prev_was_cr) begin
                    burst.bytes[k[IDX_W-1:0]] = CH_CR;
                    k = k + 1'b1;
                end
                burst.bytes[k[IDX_W-1:0]] = CH_LF;
                k = k + 1'b1;
                n_at_line_start = 1'b1;
            end else begin
                // A period opening a line is doubled.
                if (r_at_line_start && (i_req.data_byte == CH_DOT)) begin
                    burst.bytes[k[IDX_W-1:0]] = CH_DOT;
                    k = k + 1'b1;
                end
                burst.bytes[k[IDX_W-1:0]] = i_req.data_byte;
                k = k + 1'b1;
                n_at_line_start = 1'b0;
            end
            n_prev_was_cr   = (i_req.data_byte == CH_CR);
            n_body_nonempty = 1'b1;
        end else begin
            // Close an open line (or give an empty body its CR LF), then send the terminator.
            if (!r_body_nonempty || (!r_at_line_start && !r_prev_was_cr)) begin
                burst.bytes[k[IDX_W-1:0]] = CH_CR;
                k = k + 1'b1;
            end
            if (!r_body_nonempty || !r_at_line_start) begin
                burst.bytes[k[IDX_W-1:0]] = CH_LF;
                k = k + 1'b1;
            end
            burst.bytes[k[IDX_W-1:0]] = CH_DOT;
            k = k + 1'b1;
            burst.bytes[k[IDX_W-1:0]] = CH_CR;
            k = k + 1'b1;
            burst.bytes[k[IDX_W-1:0]] = CH_LF;
            k = k + 1'b1;
            n_at_line_start = 1'b1;
            n_prev_was_cr   = 1'b0;
            n_body_nonempty = 1'b0;
        end
        burst.cnt = k;
    end

    assign o_burst = burst;

    // Line state advances only on an accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_line_start <= 1'b1;
            r_prev_was_cr   <= 1'b0;
            r_body_nonempty <= 1'b0;
        end else if (i_accept) begin
            r_at_line_start <= n_at_line_start;
            r_prev_was_cr   <= n_prev_was_cr;
            r_body_nonempty <= n_body_nonempty;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/smtp_ds_burst.sv
// Result register that holds one burst and hands its bytes out in order.
`default_nettype none

module smtp_ds_burst (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_load,
    input  smtp_ds_pkg::t_burst  i_burst,
    output logic                 o_busy,
    output logic                 o_valid,
    input  wire                  i_stall,
    output smtp_ds_pkg::t_rsp    o_rsp
);
    import smtp_ds_pkg::*;

    logic             r_valid;
    logic [IDX_W-1:0] r_idx;
    t_burst           r_burst;

    logic             is_last;
    logic             take;
    logic [7:0]       cur_byte;

    // Pick the current byte of the held burst.
    always_comb begin
        cur_byte = '0;
        for (int i = 0; i < MAX_BYTES; i++) begin
            if (r_idx == IDX_W'(i)) begin
                cur_byte = r_burst.bytes[i];
            end
        end
    end

    assign is_last = (CNT_W'(r_idx) == CNT_W'(r_burst.cnt - 1'b1));
    assign take    = r_valid && !i_stall;

    // A new burst may load in the cycle the last byte of the old one leaves.
    assign o_busy  = r_valid && !(take && is_last);
    assign o_valid = r_valid;
    assign o_rsp   = '{out_byte: cur_byte, last: is_last};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (take && is_last) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // Burst payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_burst <= i_burst;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/smtp_ds_checker.sv
// Port-level checks of the SMTP DATA encoder and their binding to the top.
`default_nettype none

module smtp_ds_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_valid,
    input wire                 o_stall,
    input wire                 o_valid,
    input wire                 i_stall,
    input smtp_ds_pkg::t_rsp   o_rsp
);

    // The input is held back only while a result waits.
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no pending result");

    // Every accepted request shows a result in the next cycle.
    a_request_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_valid)
        else $error("accepted request produced no result");

    // A burst continues until its last byte has been sent.
    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_rsp.last) |=> o_valid)
        else $error("burst ended without a last byte");

    // A stalled result keeps its payload.
    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_rsp)))
        else $error("stalled result changed");

endmodule

bind smtp_dot_stuff_crlf_encoder_core smtp_ds_checker u_smtp_ds_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_rsp   (o_rsp)
);

`default_nettype wire

FILE: bench/tb_smtp_dot_stuff_crlf_encoder_core.sv
// Self-checking testbench for the SMTP DATA encoder with dot stuffing and CR LF repair.
`default_nettype none

module tb_smtp_dot_stuff_crlf_encoder_core;
    timeunit 1ns;
    timeprecision 1ps;

    import smtp_ds_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 9;
    localparam int RANDOM_ITEMS   = 135;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_STALL_RUN  = 6;

    // One directed request, with its byte burst typed in where it is obvious.
    // A zero byte count means the expected burst comes from the encoder model.
    typedef struct packed {
        logic        req_type;
        logic [7:0]  data_byte;
        logic [2:0]  n_bytes;
        logic [39:0] bytes;
    } t_row;

    localparam int DIR_LEN = 25;
    localparam t_row DIRECTED_ROWS [DIR_LEN] = '{
        // Empty body right after reset.
        '{REQ_EOB,  8'h00,  3'd5, {CH_CR, CH_LF, CH_DOT, CH_CR, CH_LF}},
        // Period at line start, then plain and extreme bytes mid-line.
        '{REQ_BODY, CH_DOT, 3'd2, {CH_DOT, CH_DOT, 24'h0}},
        '{REQ_BODY, "a",    3'd1, {"a", 32'h0}},
        '{REQ_BODY, CH_DOT, 3'd1, {CH_DOT, 32'h0}},
        '{REQ_BODY, 8'h00,  3'd1, {8'h00, 32'h0}},
        '{REQ_BODY, 8'hFF,  3'd1, {8'hFF, 32'h0}},
        // Bare LF is repaired, also on an empty line.
        '{REQ_BODY, CH_LF,  3'd2, {CH_CR, CH_LF, 24'h0}},
        '{REQ_BODY, CH_LF,  3'd2, {CH_CR, CH_LF, 24'h0}},
        // Proper CR LF passes through untouched.
        '{REQ_BODY, CH_CR,  3'd1, {CH_CR, 32'h0}},
        '{REQ_BODY, CH_LF,  3'd1, {CH_LF, 32'h0}},
        '{REQ_BODY, CH_DOT, 3'd2, {CH_DOT, CH_DOT, 24'h0}},
        // Lone CR inside a line.
        '{REQ_BODY, CH_CR,  3'd1, {CH_CR, 32'h0}},
        '{REQ_BODY, "y",    3'd0, 40'h0},
        // Body ends mid-line; the data byte of end of body is ignored.
        '{REQ_EOB,  8'hFF,  3'd5, {CH_CR, CH_LF, CH_DOT, CH_CR, CH_LF}},
        // A final line holding only a period still gets doubled and closed.
        '{REQ_BODY, CH_DOT, 3'd2, {CH_DOT, CH_DOT, 24'h0}},
        '{REQ_EOB,  8'h00,  3'd5, {CH_CR, CH_LF, CH_DOT, CH_CR, CH_LF}},
        // Body ending in CR needs only the LF.
        '{REQ_BODY, "z",    3'd0, 40'h0},
        '{REQ_BODY, CH_CR,  3'd1, {CH_CR, 32'h0}},
        '{REQ_EOB,  8'h00,  3'd4, {CH_LF, CH_DOT, CH_CR, CH_LF, 8'h0}},
        // Body ending in LF gets just the terminator.
        '{REQ_BODY, "q",    3'd0, 40'h0},
        '{REQ_BODY, CH_LF,  3'd2, {CH_CR, CH_LF, 24'h0}},
        '{REQ_EOB,  8'h00,  3'd3, {CH_DOT, CH_CR, CH_LF, 16'h0}},
        // CR at line start moves off the line start, so the period is single.
        '{REQ_BODY, CH_CR,  3'd1, {CH_CR, 32'h0}},
        '{REQ_BODY, CH_DOT, 3'd0, 40'h0},
        '{REQ_EOB,  8'h55,  3'd0, 40'h0}
    };

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_req i_req;
    logic o_valid;
    logic i_stall = 1'b0;
    t_rsp o_rsp;

    smtp_dot_stuff_crlf_encoder_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

    // Encoder model state and the bytes it expects on the output.
    logic       line_start = 1'b1;
    logic       after_cr   = 1'b0;
    logic       body_seen  = 1'b0;
    logic [7:0] model_burst [$];
    t_rsp       pending_bytes [$];

    int errors        = 0;
    int requests_sent = 0;
    int messages_sent = 0;
    int bytes_checked = 0;
    int dots_doubled  = 0;
    int lf_repaired   = 0;
    int burst_left    = 0;
    int gap_left      = 0;
    int idle_cycles   = 0;

    // Receiver stall pattern state.
    int stall_mode      = 0;
    int stall_mode_left = 0;
    int stall_run       = 0;
    int stall_period    = 2;
    int stall_phase     = 0;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Compute the output burst of one request and advance the line state.
    function void encode_request(input t_req r);
        model_burst.delete();
        if (r.req_type == REQ_BODY) begin
            if (r.data_byte == CH_LF) begin
                if (!after_cr) begin
                    model_burst.push_back(CH_CR);
                    lf_repaired++;
                end
                model_burst.push_back(CH_LF);
                line_start = 1'b1;
            end else begin
                if (line_start && r.data_byte == CH_DOT) begin
                    model_burst.push_back(CH_DOT);
                    dots_doubled++;
                end
                model_burst.push_back(r.data_byte);
                line_start = 1'b0;
            end
            after_cr  = (r.data_byte == CH_CR);
            body_seen = 1'b1;
        end else begin
            // Close an open line (or give an empty body its CR LF), then send the terminator.
            if (!body_seen) begin
                model_burst.push_back(CH_CR);
                model_burst.push_back(CH_LF);
            end else if (!line_start) begin
                if (!after_cr)
                    model_burst.push_back(CH_CR);
                model_burst.push_back(CH_LF);
            end
            model_burst.push_back(CH_DOT);
            model_burst.push_back(CH_CR);
            model_burst.push_back(CH_LF);
            line_start = 1'b1;
            after_cr   = 1'b0;
            body_seen  = 1'b0;
            messages_sent++;
        end
    endfunction

    task report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
        $display("MISMATCH at output byte %0d: %s, got %02h, want %02h",
                 bytes_checked, what, got, want);
        errors++;
    endtask

    // Offer one request with burst/gap pacing and queue its expected bytes once taken.
    task automatic send_request(input logic kind, input logic [7:0] data,
                                input int n_typed, input logic [39:0] typed);
        t_req r;
        t_rsp b;
        r.req_type  = kind;
        r.data_byte = data;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50)
                                                     : $urandom_range(1, 8);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        while (gap_left > 0) begin
            i_valid <= 1'b0;
            i_req   <= t_req'($urandom_range(0, 511));
            @(posedge i_clk);
            gap_left--;
        end
        i_valid <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_stall);
        burst_left--;
        requests_sent++;
        encode_request(r);
        if (n_typed == 0) begin
            for (int i = 0; i < model_burst.size(); i++) begin
                b.out_byte = model_burst[i];
                b.last     = (i == model_burst.size() - 1);
                pending_bytes.push_back(b);
            end
        end else begin
            for (int i = 0; i < n_typed; i++) begin
                b.out_byte = typed[39 - 8*i -: 8];
                b.last     = (i == n_typed - 1);
                pending_bytes.push_back(b);
            end
        end
    endtask

    // Mostly random bytes, with plenty of periods and line ends.
    function logic [7:0] pick_body_byte();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 18)
            return CH_DOT;
        else if (pick < 32)
            return CH_LF;
        else if (pick < 42)
            return CH_CR;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // Stimulus: reset, directed table, then random messages.
    initial begin
        int random_sent;
        int body_len;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_req   <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_LEN; i++)
            send_request(DIRECTED_ROWS[i].req_type, DIRECTED_ROWS[i].data_byte,
                         int'(DIRECTED_ROWS[i].n_bytes), DIRECTED_ROWS[i].bytes);

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            body_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(0, 8);
            for (int k = 0; k < body_len; k++)
                send_request(REQ_BODY, pick_body_byte(), 0, 40'h0);
            send_request(REQ_EOB, 8'($urandom_range(0, 255)), 0, 40'h0);
            random_sent += body_len + 1;
        end
        i_valid <= 1'b0;

        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests (%0d directed) in %0d messages.",
                 requests_sent, DIR_LEN, messages_sent);
        $display("Checked %0d output bytes; %0d periods doubled, %0d bare LFs repaired.",
                 bytes_checked, dots_doubled, lf_repaired);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Output check and receiver stall pattern.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_bytes.size() == 0) begin
                report_mismatch("byte with none expected", o_rsp.out_byte, 8'h00);
            end else begin
                if (o_rsp.out_byte !== pending_bytes[0].out_byte)
                    report_mismatch("out_byte", o_rsp.out_byte, pending_bytes[0].out_byte);
                if (o_rsp.last !== pending_bytes[0].last)
                    report_mismatch("last", 8'(o_rsp.last), 8'(pending_bytes[0].last));
                void'(pending_bytes.pop_front());
            end
            bytes_checked++;
        end

        // Switch between free flow, light random, periodic and heavy stalling.
        if (stall_mode_left == 0) begin
            stall_mode      = $urandom_range(0, 3);
            stall_mode_left = $urandom_range(20, 200);
            stall_period    = $urandom_range(2, 5);
            stall_phase     = 0;
        end
        stall_mode_left--;
        stall_phase = (stall_phase + 1) % stall_period;
        if (stall_run >= MAX_STALL_RUN) begin
            i_stall   <= 1'b0;
            stall_run = 0;
        end else begin
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 99) < 30);
                2: i_stall <= (stall_phase == 0);
                default: i_stall <= ($urandom_range(0, 99) < 75);
            endcase
            stall_run = i_stall ? stall_run + 1 : 0;
        end
    end

    // Watchdog: ends the run when neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles, %0d bytes still expected",
                     idle_cycles, pending_bytes.size());
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule

`default_nettype wire
